[rtl/e2r_pkg.sv]
// shared types, constants and fixed-point helpers for the euler to rotation basis block
`timescale 1ns / 1ps

package e2r_pkg;

    // field widths
    localparam int ANGLE_BITS  = 16;
    localparam int FRAC_BITS   = 14;
    localparam int OUT_BITS    = FRAC_BITS + 2;
    localparam int PHASE_SHIFT = 32 - ANGLE_BITS;
    localparam int OUT_SHIFT   = 30 - FRAC_BITS;

    // pipeline geometry
    localparam int N_SLOTS      = 5;
    localparam int FRONT_STAGES = 3 * N_SLOTS + 3;
    localparam int BACK_STAGES  = 4;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    typedef logic [30:0]                 mag_t;
    typedef logic signed [31:0]          q30_t;
    typedef logic signed [32:0]          sum_t;
    typedef logic [6:0]                  divisor_t;
    typedef logic [31:0]                 recip_t;
    typedef logic signed [OUT_BITS-1:0]  out_word_t;

    localparam mag_t Q_ONE       = 31'h4000_0000;
    localparam mag_t HALF_PI_Q30 = 31'd1686629713;

    // reciprocals for the constant divisions, floor(2^32 / d)
    localparam longint TWO32 = 64'sd4294967296;
    localparam recip_t RECIP_72 = recip_t'(TWO32 / 72);
    localparam recip_t RECIP_42 = recip_t'(TWO32 / 42);
    localparam recip_t RECIP_20 = recip_t'(TWO32 / 20);
    localparam recip_t RECIP_6  = recip_t'(TWO32 / 6);
    localparam recip_t RECIP_90 = recip_t'(TWO32 / 90);
    localparam recip_t RECIP_56 = recip_t'(TWO32 / 56);
    localparam recip_t RECIP_30 = recip_t'(TWO32 / 30);
    localparam recip_t RECIP_12 = recip_t'(TWO32 / 12);
    localparam recip_t RECIP_2  = recip_t'(TWO32 / 2);

    typedef struct packed {
        logic [ANGLE_BITS-1:0] yaw_angle;
        logic [ANGLE_BITS-1:0] pitch_angle;
        logic [ANGLE_BITS-1:0] roll_angle;
    } e2r_in_t;

    typedef struct packed {
        out_word_t fwd_x;
        out_word_t fwd_y;
        out_word_t fwd_z;
        out_word_t left_x;
        out_word_t left_y;
        out_word_t left_z;
        out_word_t up_x;
        out_word_t up_y;
        out_word_t up_z;
    } e2r_out_t;

    typedef struct packed {
        q30_t sy;
        q30_t cy;
        q30_t sp;
        q30_t cp;
        q30_t sr;
        q30_t cr;
    } e2r_trig_t;

    // series divisors per slot
    function automatic divisor_t sin_divisor(input int i);
        case (i)
            0:       sin_divisor = 7'd72;
            1:       sin_divisor = 7'd42;
            2:       sin_divisor = 7'd20;
            3:       sin_divisor = 7'd6;
            default: sin_divisor = 7'd1;
        endcase
    endfunction

    function automatic recip_t sin_recip(input int i);
        case (i)
            0:       sin_recip = RECIP_72;
            1:       sin_recip = RECIP_42;
            2:       sin_recip = RECIP_20;
            3:       sin_recip = RECIP_6;
            default: sin_recip = '0;
        endcase
    endfunction

    function automatic divisor_t cos_divisor(input int i);
        case (i)
            0:       cos_divisor = 7'd90;
            1:       cos_divisor = 7'd56;
            2:       cos_divisor = 7'd30;
            3:       cos_divisor = 7'd12;
            default: cos_divisor = 7'd2;
        endcase
    endfunction

    function automatic recip_t cos_recip(input int i);
        case (i)
            0:       cos_recip = RECIP_90;
            1:       cos_recip = RECIP_56;
            2:       cos_recip = RECIP_30;
            3:       cos_recip = RECIP_12;
            default: cos_recip = RECIP_2;
        endcase
    endfunction

    // unsigned q30 product, round half up
    function automatic mag_t umul_q(input mag_t a, input mag_t b);
        logic [61:0] p;
        p = {31'd0, a} * {31'd0, b} + (62'd1 << 29);
        umul_q = p[60:30];
    endfunction

    // signed q30 product, magnitude rounded half up
    function automatic q30_t smul_q(input q30_t a, input q30_t b);
        logic neg;
        q30_t na;
        q30_t nb;
        mag_t ma;
        mag_t mb;
        mag_t m;
        neg = a[31] ^ b[31];
        na  = -a;
        nb  = -b;
        ma  = a[31] ? na[30:0] : a[30:0];
        mb  = b[31] ? nb[30:0] : b[30:0];
        m   = umul_q(ma, mb);
        smul_q = neg ? -q30_t'({1'b0, m}) : q30_t'({1'b0, m});
    endfunction

    // quotient estimate by reciprocal, low by at most one
    function automatic mag_t div_est(input mag_t y, input recip_t m);
        logic [62:0] p;
        p = {32'd0, y} * {31'd0, m};
        div_est = p[62:32];
    endfunction

    // one correction step of the estimate
    function automatic mag_t div_fix(input mag_t y, input mag_t q0, input divisor_t d);
        logic [37:0] qd;
        mag_t r;
        qd = {7'd0, q0} * {31'd0, d};
        r  = y - qd[30:0];
        div_fix = (r >= {24'd0, d}) ? q0 + 31'd1 : q0;
    endfunction

    // q30 to output format, round half away from zero, saturate
    function automatic out_word_t to_out(input sum_t v);
        logic neg;
        sum_t nv;
        logic [32:0] m;
        logic [33:0] mr;
        neg = v[32];
        nv  = -v;
        m   = neg ? nv : v;
        if (OUT_SHIFT > 0)
            mr = ({1'b0, m} + (34'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        else
            mr = {1'b0, m};
        if (mr > (34'd1 << FRAC_BITS))
            mr = 34'd1 << FRAC_BITS;
        to_out = neg ? -out_word_t'(mr) : out_word_t'(mr);
    endfunction

endpackage

[rtl/e2r_sincos.sv]
// one sine and cosine lane: octant fold, series evaluation, quadrant mapping
`timescale 1ns / 1ps

module e2r_sincos (
    input  logic                            clk,
    input  logic                            en,
    input  logic [e2r_pkg::ANGLE_BITS-1:0]  angle,
    output e2r_pkg::q30_t                   sin_q,
    output e2r_pkg::q30_t                   cos_q
);
    import e2r_pkg::*;

    typedef struct packed {
        mag_t       u;
        mag_t       t;
        logic [1:0] quad;
        logic       swap;
    } side_t;

    localparam int SIDE_LEN = 3 * N_SLOTS + 1;

    logic [31:0] phase;
    mag_t        fold;
    mag_t        t1_reg;
    logic [1:0]  quad1_reg;
    logic        swap1_reg;
    side_t       side_reg [SIDE_LEN];

    mag_t xs_reg [N_SLOTS];
    mag_t xc_reg [N_SLOTS];
    mag_t ys_reg [N_SLOTS];
    mag_t yc_reg [N_SLOTS];
    mag_t qs_reg [N_SLOTS];
    mag_t qc_reg [N_SLOTS];
    mag_t hs_reg [N_SLOTS];
    mag_t hc_reg [N_SLOTS];

    q30_t sv;
    q30_t cv;
    q30_t s0;
    q30_t c0;
    q30_t sin_next;
    q30_t cos_next;
    q30_t sin_reg;
    q30_t cos_reg;

    // phase, fold to an eighth turn
    assign phase = 32'(angle) << PHASE_SHIFT;
    assign fold  = phase[29] ? (Q_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};

    // argument in radians, then its square
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg      <= umul_q(fold, HALF_PI_Q30);
            quad1_reg   <= phase[31:30];
            swap1_reg   <= phase[29];
            side_reg[0] <= '{u: umul_q(t1_reg, t1_reg), t: t1_reg,
                             quad: quad1_reg, swap: swap1_reg};
        end
    end

    // sideband follows the series stages
    for (genvar j = 1; j < SIDE_LEN; j++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
                side_reg[j] <= side_reg[j-1];
        end
    end

    // series slots: product, quotient estimate, correction
    for (genvar i = 0; i < N_SLOTS; i++)
    begin : g_slot
        localparam divisor_t DS = sin_divisor(i);
        localparam recip_t   MS = sin_recip(i);
        localparam divisor_t DC = cos_divisor(i);
        localparam recip_t   MC = cos_recip(i);

        mag_t xs_next;
        mag_t xc_next;

        if (i == 0)
        begin : g_first
            assign xs_next = side_reg[0].u;
            assign xc_next = side_reg[0].u;
        end
        else if (i == N_SLOTS - 1)
        begin : g_last
            assign xs_next = umul_q(side_reg[3*i].t, hs_reg[i-1]);
            assign xc_next = umul_q(side_reg[3*i].u, hc_reg[i-1]);
        end
        else
        begin : g_mid
            assign xs_next = umul_q(side_reg[3*i].u, hs_reg[i-1]);
            assign xc_next = umul_q(side_reg[3*i].u, hc_reg[i-1]);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                xs_reg[i] <= xs_next;
                xc_reg[i] <= xc_next;
                ys_reg[i] <= xs_reg[i] + {24'd0, DS >> 1};
                yc_reg[i] <= xc_reg[i] + {24'd0, DC >> 1};
                qs_reg[i] <= div_est(xs_reg[i] + {24'd0, DS >> 1}, MS);
                qc_reg[i] <= div_est(xc_reg[i] + {24'd0, DC >> 1}, MC);
                hc_reg[i] <= Q_ONE - div_fix(yc_reg[i], qc_reg[i], DC);
                if (i == N_SLOTS - 1)
                    hs_reg[i] <= ys_reg[i] - {24'd0, DS >> 1};
                else
                    hs_reg[i] <= Q_ONE - div_fix(ys_reg[i], qs_reg[i], DS);
            end
        end
    end

    // undo the fold and map the quadrant
    assign sv = q30_t'({1'b0, hs_reg[N_SLOTS-1]});
    assign cv = q30_t'({1'b0, hc_reg[N_SLOTS-1]});
    assign s0 = side_reg[SIDE_LEN-1].swap ? cv : sv;
    assign c0 = side_reg[SIDE_LEN-1].swap ? sv : cv;

    always_comb
    begin
        case (side_reg[SIDE_LEN-1].quad)
            2'd0:
            begin
                sin_next = s0;
                cos_next = c0;
            end
            2'd1:
            begin
                sin_next = c0;
                cos_next = -s0;
            end
            2'd2:
            begin
                sin_next = -s0;
                cos_next = -c0;
            end
            default:
            begin
                sin_next = -c0;
                cos_next = s0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

[rtl/e2r_front.sv]
// front part: accepts angle items and turns them into sines and cosines
`timescale 1ns / 1ps

module e2r_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                angles_valid,
    output logic                angles_ready,
    input  e2r_pkg::e2r_in_t    angles,
    output logic                trig_valid,
    input  logic                trig_ready,
    output e2r_pkg::e2r_trig_t  trig
);
    import e2r_pkg::*;

    logic                    en;
    logic [FRONT_STAGES-1:0] vld_reg;
    logic [FRONT_STAGES-1:0] vld_next;

    // whole pipe moves unless the last item is blocked
    assign en           = !vld_reg[FRONT_STAGES-1] || trig_ready;
    assign angles_ready = en;
    assign vld_next     = {vld_reg[FRONT_STAGES-2:0], angles_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // three lanes in lockstep
    e2r_sincos u_yaw (
        .clk   (clk),
        .en    (en),
        .angle (angles.yaw_angle),
        .sin_q (trig.sy),
        .cos_q (trig.cy)
    );

    e2r_sincos u_pitch (
        .clk   (clk),
        .en    (en),
        .angle (angles.pitch_angle),
        .sin_q (trig.sp),
        .cos_q (trig.cp)
    );

    e2r_sincos u_roll (
        .clk   (clk),
        .en    (en),
        .angle (angles.roll_angle),
        .sin_q (trig.sr),
        .cos_q (trig.cr)
    );

    assign trig_valid = vld_reg[FRONT_STAGES-1];

endmodule

[rtl/e2r_queue.sv]
// short item queue between the front and back parts
`timescale 1ns / 1ps

module e2r_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  e2r_pkg::e2r_trig_t  push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output e2r_pkg::e2r_trig_t  pop_data
);
    import e2r_pkg::*;

    e2r_trig_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // occupancy checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count past depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not rise on push");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not fall on pop");

endmodule

[rtl/e2r_back.sv]
// back part: products, sums and output rounding of the basis
`timescale 1ns / 1ps

module e2r_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                trig_valid,
    output logic                trig_ready,
    input  e2r_pkg::e2r_trig_t  trig,
    output logic                basis_valid,
    input  logic                basis_ready,
    output e2r_pkg::e2r_out_t   basis
);
    import e2r_pkg::*;

    logic                   en;
    logic [BACK_STAGES-1:0] vld_reg;

    // first products
    q30_t cycp_reg, sycp_reg, cysp_reg, sysp_reg, cpsr_reg, cpcr_reg;
    q30_t sp1_reg, sy1_reg, cy1_reg, sr1_reg, cr1_reg;

    // second products
    q30_t cyspsr_reg, sycr_reg, syspsr_reg, cycr_reg;
    q30_t cyspcr_reg, sysr_reg, syspcr_reg, cysr_reg;
    q30_t cycp2_reg, sycp2_reg, sp2_reg, cpsr2_reg, cpcr2_reg;

    // sums
    sum_t     pre_reg [9];
    e2r_out_t basis_reg;

    assign en         = !vld_reg[BACK_STAGES-1] || basis_ready;
    assign trig_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[BACK_STAGES-2:0], trig_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cycp_reg   <= smul_q(trig.cy, trig.cp);
            sycp_reg   <= smul_q(trig.sy, trig.cp);
            cysp_reg   <= smul_q(trig.cy, trig.sp);
            sysp_reg   <= smul_q(trig.sy, trig.sp);
            cpsr_reg   <= smul_q(trig.cp, trig.sr);
            cpcr_reg   <= smul_q(trig.cp, trig.cr);
            sp1_reg    <= trig.sp;
            sy1_reg    <= trig.sy;
            cy1_reg    <= trig.cy;
            sr1_reg    <= trig.sr;
            cr1_reg    <= trig.cr;

            cyspsr_reg <= smul_q(cysp_reg, sr1_reg);
            cyspcr_reg <= smul_q(cysp_reg, cr1_reg);
            syspsr_reg <= smul_q(sysp_reg, sr1_reg);
            syspcr_reg <= smul_q(sysp_reg, cr1_reg);
            sycr_reg   <= smul_q(sy1_reg, cr1_reg);
            cycr_reg   <= smul_q(cy1_reg, cr1_reg);
            sysr_reg   <= smul_q(sy1_reg, sr1_reg);
            cysr_reg   <= smul_q(cy1_reg, sr1_reg);
            cycp2_reg  <= cycp_reg;
            sycp2_reg  <= sycp_reg;
            sp2_reg    <= sp1_reg;
            cpsr2_reg  <= cpsr_reg;
            cpcr2_reg  <= cpcr_reg;

            pre_reg[0] <= sum_t'(cycp2_reg);
            pre_reg[1] <= sum_t'(sycp2_reg);
            pre_reg[2] <= -sum_t'(sp2_reg);
            pre_reg[3] <= sum_t'(cyspsr_reg) - sum_t'(sycr_reg);
            pre_reg[4] <= sum_t'(syspsr_reg) + sum_t'(cycr_reg);
            pre_reg[5] <= sum_t'(cpsr2_reg);
            pre_reg[6] <= sum_t'(cyspcr_reg) + sum_t'(sysr_reg);
            pre_reg[7] <= sum_t'(syspcr_reg) - sum_t'(cysr_reg);
            pre_reg[8] <= sum_t'(cpcr2_reg);

            basis_reg.fwd_x  <= to_out(pre_reg[0]);
            basis_reg.fwd_y  <= to_out(pre_reg[1]);
            basis_reg.fwd_z  <= to_out(pre_reg[2]);
            basis_reg.left_x <= to_out(pre_reg[3]);
            basis_reg.left_y <= to_out(pre_reg[4]);
            basis_reg.left_z <= to_out(pre_reg[5]);
            basis_reg.up_x   <= to_out(pre_reg[6]);
            basis_reg.up_y   <= to_out(pre_reg[7]);
            basis_reg.up_z   <= to_out(pre_reg[8]);
        end
    end

    assign basis_valid = vld_reg[BACK_STAGES-1];
    assign basis       = basis_reg;

endmodule

[rtl/euler_to_rotation_basis_top.sv]
// an angle item passes the sine and cosine pipeline, the queue and the product
//   pipeline in that order before it is shown as a basis item
// throughput: one item per cycle while the output is not held
// a four-item queue lets the sine pipeline run while the output is held, until it fills
// reset: asynchronous, clears valid bits, queue pointers and count; no other state
`timescale 1ns / 1ps

module euler_to_rotation_basis_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               angles_valid,
    output logic               angles_ready,
    input  e2r_pkg::e2r_in_t   angles,
    output logic               basis_valid,
    input  logic               basis_ready,
    output e2r_pkg::e2r_out_t  basis
);
    import e2r_pkg::*;

    logic      f_valid;
    logic      f_ready;
    e2r_trig_t f_data;
    logic      b_valid;
    logic      b_ready;
    e2r_trig_t b_data;

    // angles to sines and cosines
    e2r_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .angles_valid (angles_valid),
        .angles_ready (angles_ready),
        .angles       (angles),
        .trig_valid   (f_valid),
        .trig_ready   (f_ready),
        .trig         (f_data)
    );

    // decoupling queue
    e2r_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_data)
    );

    // basis products and rounding
    e2r_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .trig_valid  (b_valid),
        .trig_ready  (b_ready),
        .trig        (b_data),
        .basis_valid (basis_valid),
        .basis_ready (basis_ready),
        .basis       (basis)
    );

endmodule
